/* hw/rtl/thumb_load_address_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// Thumb load address sequencer assertion macros
// Shared assertion forms for the load address sequencer, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef THUMB_LOAD_ADDRESS_SEQUENCER_DEFINES_SVH
`define THUMB_LOAD_ADDRESS_SEQUENCER_DEFINES_SVH

// Same-cycle implication.
`define TLAS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("load address sequencer: same-cycle check failed");

// Next-cycle implication.
`define TLAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("load address sequencer: next-cycle check failed");

`endif

/* hw/rtl/tlas_pkg.sv */
// ----------------------------------------------------------------------------
// Thumb load address sequencer package
// Command codes, field widths and helpers shared by the sequencer files.
// ----------------------------------------------------------------------------
package tlas_pkg;

    localparam int NUM_LOW_REGS = 8;
    localparam int REG_IDX_W    = 3;
    localparam int WORD_W       = 32;
    localparam int INSTR_W      = 16;
    localparam int LIST_W       = 8;

    localparam logic [WORD_W-1:0] ALIGN_MASK = 32'hFFFF_FFFC;

    typedef logic [1:0] command_t;

    localparam command_t CMD_LDR_LIT = 2'd0;
    localparam command_t CMD_LDR_IMM = 2'd1;
    localparam command_t CMD_LDM     = 2'd2;
    localparam command_t CMD_WRITE   = 2'd3;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [WORD_W-1:0]    word_t;

    // Index of the lowest set bit of a register list.
    function automatic reg_idx_t first_set(input logic [LIST_W-1:0] list);
        reg_idx_t idx;
        idx = '0;
        for (int i = LIST_W - 1; i >= 0; i--)
        begin
            if (list[i])
            begin
                idx = REG_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* hw/rtl/tlas_ram.sv */
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tlas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/thumb_load_address_sequencer.sv */
// ----------------------------------------------------------------------------
// Thumb load address sequencer
// Turns Thumb LDR literal, LDR immediate and LDM into word read requests,
// holding R0-R7 in a small synchronous register-file RAM.
// ----------------------------------------------------------------------------
// Usage:
// Words arrive on the s_axis channel; tuser carries the command and tdata the
// instruction halfword, pc and the register-write index and data. Results
// leave on the m_axis channel, one word per read request, with tlast on the
// final word of each instruction and base writeback flagged in tuser.
// A register write goes to the RAM on acceptance and gives no result. LDR
// literal forms its address on acceptance and reaches the output register
// from the EMIT state. LDR immediate and LDM first read their base from the
// registered register-file RAM in the BASE state, then move to EMIT. LDM
// then gives one result per cycle while the receiver takes them, lowest
// listed register first; an empty list gives a single word without a read.
// The input is ready again as soon as the last result sits in the output
// register. When the receiver stalls, the output register holds its word and
// the sequencer waits. Reset empties the pipeline and marks every register as
// unwritten; an unwritten register reads as zero, so no clearing pass runs.
// ----------------------------------------------------------------------------
`include "thumb_load_address_sequencer_defines.svh"

module thumb_load_address_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] instruction, [47:16] pc, [50:48] write_index,
    // [82:51] write_data, [87:83] zero
    input  logic [87:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] read_address, [34:32] dest_register, [66:35] base_value,
    // [71:67] zero
    output logic [71:0] m_axis_tdata,
    // [0] read_valid, [1] base_updated
    output logic [1:0]  m_axis_tuser,
    // last
    output logic        m_axis_tlast
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BASE = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;

    // Instruction context.
    tlas_pkg::command_t                cmd_reg, cmd_next;
    logic [tlas_pkg::INSTR_W-1:0]      instr_reg, instr_next;
    tlas_pkg::word_t                   addr_reg, addr_next;
    logic [tlas_pkg::LIST_W-1:0]       list_reg, list_next;

    // Written flags for the register file; an unwritten entry reads as zero.
    logic [tlas_pkg::NUM_LOW_REGS-1:0] written_reg, written_next;
    logic                              rd_ok_reg, rd_ok_next;

    // Output register.
    logic                              out_valid_reg, out_valid_next;
    tlas_pkg::word_t                   out_addr_reg, out_addr_next;
    tlas_pkg::reg_idx_t                out_dest_reg, out_dest_next;
    logic                              out_rv_reg, out_rv_next;
    logic                              out_last_reg, out_last_next;
    logic                              out_upd_reg, out_upd_next;
    tlas_pkg::word_t                   out_base_reg, out_base_next;

    // Input fields.
    tlas_pkg::command_t           in_cmd;
    logic [tlas_pkg::INSTR_W-1:0] in_instr;
    tlas_pkg::word_t              in_pc;
    tlas_pkg::reg_idx_t           in_widx;
    tlas_pkg::word_t              in_wdata;

    // RAM ports.
    logic               ram_we;
    tlas_pkg::reg_idx_t ram_waddr;
    tlas_pkg::word_t    ram_wdata;
    logic               ram_re;
    tlas_pkg::reg_idx_t ram_raddr;
    tlas_pkg::word_t    ram_rdata;

    logic               s_accept;
    logic               load;
    tlas_pkg::word_t    base_word;
    tlas_pkg::reg_idx_t ldm_rn;
    logic               ldm_wback;
    logic               ldm_single;

    assign in_cmd   = s_axis_tuser;
    assign in_instr = s_axis_tdata[15:0];
    assign in_pc    = s_axis_tdata[47:16];
    assign in_widx  = s_axis_tdata[50:48];
    assign in_wdata = s_axis_tdata[82:51];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // A new result may enter the output register when it is empty or draining.
    assign load = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);

    assign base_word  = rd_ok_reg ? ram_rdata : '0;
    assign ldm_rn     = instr_reg[10:8];
    assign ldm_wback  = !instr_reg[ldm_rn];
    assign ldm_single = ((list_reg & (list_reg - 8'd1)) == '0);

    // The base register is read on the accepting edge, so its data is ready
    // in the following cycle. Writes and reads never overlap: a register write
    // is a word of its own, and LDM writes back only after its read is done.
    assign ram_re    = s_accept && ((in_cmd == tlas_pkg::CMD_LDR_IMM) ||
                                    (in_cmd == tlas_pkg::CMD_LDM));
    assign ram_raddr = (in_cmd == tlas_pkg::CMD_LDR_IMM) ? in_instr[5:3] : in_instr[10:8];

    tlas_ram #(
        .WIDTH (tlas_pkg::WORD_W),
        .DEPTH (tlas_pkg::NUM_LOW_REGS)
    ) u_regfile (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        instr_next     = instr_reg;
        addr_next      = addr_reg;
        list_next      = list_reg;
        written_next   = written_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = m_axis_tready ? 1'b0 : out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_dest_next  = out_dest_reg;
        out_rv_next    = out_rv_reg;
        out_last_next  = out_last_reg;
        out_upd_next   = out_upd_reg;
        out_base_next  = out_base_reg;
        ram_we         = 1'b0;
        ram_waddr      = in_widx;
        ram_wdata      = in_wdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    cmd_next   = in_cmd;
                    instr_next = in_instr;
                    rd_ok_next = written_reg[ram_raddr];
                    case (in_cmd)
                        tlas_pkg::CMD_LDR_LIT:
                        begin
                            addr_next  = ((in_pc + 32'd2) & tlas_pkg::ALIGN_MASK)
                                       + {22'd0, in_instr[7:0], 2'b00};
                            state_next = ST_EMIT;
                        end
                        tlas_pkg::CMD_LDR_IMM, tlas_pkg::CMD_LDM:
                        begin
                            state_next = ST_BASE;
                        end
                        default:
                        begin
                            ram_we = 1'b1;
                        end
                    endcase
                end
            end

            ST_BASE:
            begin
                if (cmd_reg == tlas_pkg::CMD_LDR_IMM)
                begin
                    addr_next = base_word + {25'd0, instr_reg[10:6], 2'b00};
                end
                else
                begin
                    addr_next = base_word;
                end
                list_next  = instr_reg[7:0];
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = addr_reg;
                    out_rv_next    = 1'b1;
                    out_last_next  = 1'b1;
                    out_upd_next   = 1'b0;
                    out_base_next  = '0;
                    ram_waddr      = ldm_rn;
                    if (cmd_reg == tlas_pkg::CMD_LDR_LIT)
                    begin
                        out_dest_next = instr_reg[10:8];
                        state_next    = ST_IDLE;
                    end
                    else if (cmd_reg == tlas_pkg::CMD_LDR_IMM)
                    begin
                        out_dest_next = instr_reg[2:0];
                        state_next    = ST_IDLE;
                    end
                    else if (list_reg == '0)
                    begin
                        // Empty list: no read, the base is rewritten unchanged.
                        out_addr_next = '0;
                        out_dest_next = '0;
                        out_rv_next   = 1'b0;
                        out_upd_next  = 1'b1;
                        out_base_next = addr_reg;
                        ram_we        = 1'b1;
                        ram_wdata     = addr_reg;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        // One listed register per cycle while the output can take it, lowest first.
                        out_dest_next = tlas_pkg::first_set(list_reg);
                        out_last_next = ldm_single;
                        list_next     = list_reg & (list_reg - 8'd1);
                        addr_next     = addr_reg + 32'd4;
                        if (ldm_single)
                        begin
                            state_next = ST_IDLE;
                            if (ldm_wback)
                            begin
                                out_upd_next  = 1'b1;
                                out_base_next = addr_reg + 32'd4;
                                ram_we        = 1'b1;
                                ram_wdata     = addr_reg + 32'd4;
                            end
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ram_we)
        begin
            written_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        instr_reg    <= instr_next;
        addr_reg     <= addr_next;
        list_reg     <= list_next;
        rd_ok_reg    <= rd_ok_next;
        out_addr_reg <= out_addr_next;
        out_dest_reg <= out_dest_next;
        out_rv_reg   <= out_rv_next;
        out_last_reg <= out_last_next;
        out_upd_reg  <= out_upd_next;
        out_base_reg <= out_base_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_base_reg, out_dest_reg, out_addr_reg};
    assign m_axis_tuser  = {out_upd_reg, out_rv_reg};
    assign m_axis_tlast  = out_last_reg;

    // The base lookup state is always followed directly by the emit state.
    `TLAS_ASSERT_NEXT(a_base_one_cycle, state_reg == ST_BASE, state_reg == ST_EMIT)
    // Base writeback is only ever reported on the final word.
    `TLAS_ASSERT_IMP(a_upd_on_last, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
    // A word without a read request is the single word of an empty LDM.
    `TLAS_ASSERT_IMP(a_noread_is_empty_ldm, m_axis_tvalid && !m_axis_tuser[0],
                     m_axis_tlast && m_axis_tuser[1])
    // The register file is written only by a register write or a final LDM word.
    `TLAS_ASSERT_IMP(a_ram_write_source, ram_we,
                     (s_accept && (in_cmd == tlas_pkg::CMD_WRITE)) || (load && out_last_next))

endmodule
